### rtl/dual_stack_word_engine_top_defines.svh
//------------------------------------------------------------------------------
// Dual stack word engine assertion macros
// Concurrent checks sampled on clock, disabled while reset is high.
//------------------------------------------------------------------------------
`ifndef DUAL_STACK_WORD_ENGINE_TOP_DEFINES_SVH
`define DUAL_STACK_WORD_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define DSWE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dswe check failed");

// next-cycle implication
`define DSWE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dswe check failed");

`endif

### rtl/dswe_pkg.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Dual stack word engine package
// Widths, command and status codes, controller/datapath interface structs.
//------------------------------------------------------------------------------
package dswe_pkg;

   localparam int WORD_W      = 64;
   localparam int CMD_W       = 5;
   localparam int CNT_W       = 9;
   localparam int STACK_DEPTH = 256;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH    = 5'd0,
      CMD_POP     = 5'd1,
      CMD_DROP    = 5'd2,
      CMD_DUP     = 5'd3,
      CMD_OVER    = 5'd4,
      CMD_PICK    = 5'd5,
      CMD_SWAP    = 5'd6,
      CMD_DROP2   = 5'd7,
      CMD_DUP2    = 5'd8,
      CMD_OVER2   = 5'd9,
      CMD_DEPTH   = 5'd10,
      CMD_CLEAR   = 5'd11,
      CMD_SVPUSH  = 5'd12,
      CMD_SVPOP   = 5'd13,
      CMD_SVDROP  = 5'd14,
      CMD_SVPICK  = 5'd15,
      CMD_SVDEPTH = 5'd16,
      CMD_SVCLEAR = 5'd17
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_UNDER   = 2'd1,
      ST_SHALLOW = 2'd2,
      ST_OVER    = 2'd3
   } status_type;

   // controller -> datapath phase strobes
   typedef struct packed {
      logic load;
      logic rd_a;
      logic rd_b;
      logic cap_b;
      logic wr1;
      logic wr2;
   } ctl_type;

   // datapath -> controller decode and condition flags
   typedef struct packed {
      logic under;
      logic has_read;
      logic two_read;
      logic is_pick;
      logic shallow;
      logic has_write;
      logic two_write;
   } sts_type;

endpackage

### rtl/dual_stack_word_engine_top.sv
`timescale 1ns / 1ps
// Sequencing: each command runs only the read, capture and write phases it needs, in that order,
//   then the result strobe; the phases are set by the one read and one write
//   port of each stack RAM with registered read data.
// Flow: no new word is taken while busy; the next word is taken in the strobe cycle.
// Reset: stack depths clear to zero; RAM contents are not cleared. No result stall.
//------------------------------------------------------------------------------
// Dual stack word engine
// Forth-style data stack and save stack of 64-bit words, one command per word.
//------------------------------------------------------------------------------
module dual_stack_word_engine_top #(
   parameter int STACK_DEPTH = dswe_pkg::STACK_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [dswe_pkg::CMD_W-1:0]  req_cmd,
   input  logic [dswe_pkg::WORD_W-1:0] req_push_word,
   output logic                        rsp_valid,
   output logic [dswe_pkg::WORD_W-1:0] rsp_top_word,
   output logic [1:0]                  rsp_status,
   output logic [dswe_pkg::CNT_W-1:0]  rsp_data_count,
   output logic [dswe_pkg::CNT_W-1:0]  rsp_save_count
);

   dswe_pkg::ctl_type ctl;
   dswe_pkg::sts_type sts;

   dswe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl)
   );

   dswe_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .req_cmd        (req_cmd),
      .req_push_word  (req_push_word),
      .sts            (sts),
      .rsp_top_word   (rsp_top_word),
      .rsp_status     (rsp_status),
      .rsp_data_count (rsp_data_count),
      .rsp_save_count (rsp_save_count)
   );

endmodule

### rtl/dswe_ram.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Dual stack word engine RAM
// Generic single write port, single read port RAM with registered read data.
//------------------------------------------------------------------------------
module dswe_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/dswe_ctrl.sv
`timescale 1ns / 1ps
`include "dual_stack_word_engine_top_defines.svh"
//------------------------------------------------------------------------------
// Dual stack word engine controller
// Sequences read, capture and write phases of one command per word.
//------------------------------------------------------------------------------
module dswe_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  dswe_pkg::sts_type sts,
   output logic              busy,
   output logic              rsp_valid,
   output dswe_pkg::ctl_type ctl
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_RA   = 7'b0000010,
      S_RB   = 7'b0000100,
      S_CB   = 7'b0001000,
      S_W1   = 7'b0010000,
      S_W2   = 7'b0100000,
      S_FIN  = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_RA;
            end
         end
         S_RA: begin
            if (sts.under) begin
               state_in = S_FIN;
            end else if (sts.has_read) begin
               state_in = S_RB;
            end else if (sts.has_write) begin
               state_in = S_W1;
            end else begin
               state_in = S_FIN;
            end
         end
         S_RB: begin
            if (sts.two_read || (sts.is_pick && !sts.shallow)) begin
               state_in = S_CB;
            end else if (sts.has_write && !sts.is_pick) begin
               state_in = S_W1;
            end else begin
               state_in = S_FIN;
            end
         end
         S_CB: begin
            state_in = S_W1;
         end
         S_W1: begin
            state_in = sts.two_write ? S_W2 : S_FIN;
         end
         S_W2: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            state_in = start ? S_RA : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = !((state_ff == S_IDLE) || (state_ff == S_FIN));
   assign rsp_valid = (state_ff == S_FIN);

   assign ctl.load  = start && !busy;
   assign ctl.rd_a  = (state_ff == S_RA);
   assign ctl.rd_b  = (state_ff == S_RB);
   assign ctl.cap_b = (state_ff == S_CB);
   assign ctl.wr1   = (state_ff == S_W1);
   assign ctl.wr2   = (state_ff == S_W2);

   `DSWE_ASSERT_NEXT(a_accept_to_ra, start && !busy, state_ff == S_RA)
   `DSWE_ASSERT_SAME(a_w2_after_w1, state_ff == S_W2, $past(state_ff) == S_W1)
   `DSWE_ASSERT_NEXT(a_under_to_fin, (state_ff == S_RA) && sts.under, state_ff == S_FIN)

endmodule

### rtl/dswe_datapath.sv
`timescale 1ns / 1ps
`include "dual_stack_word_engine_top_defines.svh"
//------------------------------------------------------------------------------
// Dual stack word engine datapath
// Stack pointers, operand registers, result registers and both stack RAMs.
//------------------------------------------------------------------------------
module dswe_datapath #(
   parameter int STACK_DEPTH = dswe_pkg::STACK_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dswe_pkg::ctl_type           ctl,
   input  logic [dswe_pkg::CMD_W-1:0]  req_cmd,
   input  logic [dswe_pkg::WORD_W-1:0] req_push_word,
   output dswe_pkg::sts_type           sts,
   output logic [dswe_pkg::WORD_W-1:0] rsp_top_word,
   output logic [1:0]                  rsp_status,
   output logic [dswe_pkg::CNT_W-1:0]  rsp_data_count,
   output logic [dswe_pkg::CNT_W-1:0]  rsp_save_count
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
   localparam int WORD_W = dswe_pkg::WORD_W;

   logic [PTR_W-1:0]          data_top_ff, data_top_in;
   logic [PTR_W-1:0]          save_top_ff, save_top_in;
   logic [dswe_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [WORD_W-1:0]         word_ff, word_in;
   logic [WORD_W-1:0]         a_ff, a_in;
   logic [WORD_W-1:0]         b_ff, b_in;
   logic [WORD_W-1:0]         popped_ff, popped_in;
   dswe_pkg::status_type      status_ff, status_in;

   logic              d_we, s_we;
   logic [ADDR_W-1:0] d_wa, s_wa, d_ra, s_ra;
   logic [WORD_W-1:0] d_wd, s_wd, d_rdata, s_rdata;

   logic [ADDR_W-1:0] d_top_a, s_top_a, idx_a;
   logic              d_full, s_full;
   logic              dpush, spush;
   logic [WORD_W-1:0] pw;

   assign d_top_a = data_top_ff[ADDR_W-1:0];
   assign s_top_a = save_top_ff[ADDR_W-1:0];
   assign idx_a   = d_rdata[ADDR_W-1:0];
   assign d_full  = (data_top_ff >= PTR_W'(STACK_DEPTH));
   assign s_full  = (save_top_ff >= PTR_W'(STACK_DEPTH));

   // command decode
   always_comb begin
      sts = '0;
      case (cmd_ff)
         dswe_pkg::CMD_PUSH, dswe_pkg::CMD_DEPTH, dswe_pkg::CMD_SVDEPTH: begin
            sts.has_write = 1'b1;
         end
         dswe_pkg::CMD_POP: begin
            sts.under    = (data_top_ff == '0);
            sts.has_read = 1'b1;
         end
         dswe_pkg::CMD_DROP: begin
            sts.under = (data_top_ff == '0);
         end
         dswe_pkg::CMD_DUP, dswe_pkg::CMD_SVPUSH: begin
            sts.under     = (data_top_ff == '0);
            sts.has_read  = 1'b1;
            sts.has_write = 1'b1;
         end
         dswe_pkg::CMD_OVER: begin
            sts.under     = (data_top_ff < PTR_W'(2));
            sts.has_read  = 1'b1;
            sts.has_write = 1'b1;
         end
         dswe_pkg::CMD_PICK: begin
            sts.under     = (data_top_ff == '0);
            sts.has_read  = 1'b1;
            sts.is_pick   = 1'b1;
            sts.has_write = 1'b1;
            sts.shallow   = (d_rdata >= WORD_W'(data_top_ff - PTR_W'(1)));
         end
         dswe_pkg::CMD_SWAP, dswe_pkg::CMD_DUP2: begin
            sts.under     = (data_top_ff < PTR_W'(2));
            sts.has_read  = 1'b1;
            sts.two_read  = 1'b1;
            sts.has_write = 1'b1;
            sts.two_write = 1'b1;
         end
         dswe_pkg::CMD_DROP2: begin
            sts.under = (data_top_ff < PTR_W'(2));
         end
         dswe_pkg::CMD_OVER2: begin
            sts.under     = (data_top_ff < PTR_W'(4));
            sts.has_read  = 1'b1;
            sts.two_read  = 1'b1;
            sts.has_write = 1'b1;
            sts.two_write = 1'b1;
         end
         dswe_pkg::CMD_SVPOP: begin
            sts.under     = (save_top_ff == '0);
            sts.has_read  = 1'b1;
            sts.has_write = 1'b1;
         end
         dswe_pkg::CMD_SVDROP: begin
            sts.under = (save_top_ff == '0);
         end
         dswe_pkg::CMD_SVPICK: begin
            sts.under     = (save_top_ff == '0) || (data_top_ff == '0);
            sts.has_read  = 1'b1;
            sts.is_pick   = 1'b1;
            sts.has_write = 1'b1;
            sts.shallow   = (d_rdata >= WORD_W'(save_top_ff));
         end
         default: begin
            sts = '0;
         end
      endcase
   end

   always_comb begin
      data_top_in = data_top_ff;
      save_top_in = save_top_ff;
      cmd_in      = cmd_ff;
      word_in     = word_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      popped_in   = popped_ff;
      status_in   = status_ff;
      d_we  = 1'b0;
      d_wa  = '0;
      d_wd  = '0;
      s_we  = 1'b0;
      s_wa  = '0;
      s_wd  = '0;
      d_ra  = '0;
      s_ra  = '0;
      dpush = 1'b0;
      spush = 1'b0;
      pw    = '0;

      if (ctl.load) begin
         cmd_in    = req_cmd;
         word_in   = req_push_word;
         status_in = dswe_pkg::ST_OK;
         popped_in = '0;
      end

      if (ctl.rd_a) begin
         case (cmd_ff)
            dswe_pkg::CMD_OVER, dswe_pkg::CMD_DUP2: begin
               d_ra = d_top_a - ADDR_W'(2);
            end
            dswe_pkg::CMD_OVER2: begin
               d_ra = d_top_a - ADDR_W'(4);
            end
            dswe_pkg::CMD_SVPOP: begin
               s_ra = s_top_a - ADDR_W'(1);
            end
            default: begin
               d_ra = d_top_a - ADDR_W'(1);
            end
         endcase
         if (sts.under) begin
            status_in = dswe_pkg::ST_UNDER;
         end else begin
            case (cmd_ff)
               dswe_pkg::CMD_DROP:    data_top_in = data_top_ff - PTR_W'(1);
               dswe_pkg::CMD_DROP2:   data_top_in = data_top_ff - PTR_W'(2);
               dswe_pkg::CMD_CLEAR:   data_top_in = '0;
               dswe_pkg::CMD_SVDROP:  save_top_in = save_top_ff - PTR_W'(1);
               dswe_pkg::CMD_SVCLEAR: save_top_in = '0;
               default:               data_top_in = data_top_ff;
            endcase
         end
      end

      if (ctl.rd_b) begin
         a_in = (cmd_ff == dswe_pkg::CMD_SVPOP) ? s_rdata : d_rdata;
         case (cmd_ff)
            dswe_pkg::CMD_SWAP: begin
               d_ra = d_top_a - ADDR_W'(2);
            end
            dswe_pkg::CMD_DUP2: begin
               d_ra = d_top_a - ADDR_W'(1);
            end
            dswe_pkg::CMD_OVER2: begin
               d_ra = d_top_a - ADDR_W'(3);
            end
            dswe_pkg::CMD_POP: begin
               popped_in   = d_rdata;
               data_top_in = data_top_ff - PTR_W'(1);
            end
            dswe_pkg::CMD_SVPUSH: begin
               data_top_in = data_top_ff - PTR_W'(1);
            end
            dswe_pkg::CMD_SVPOP: begin
               save_top_in = save_top_ff - PTR_W'(1);
            end
            dswe_pkg::CMD_PICK: begin
               data_top_in = data_top_ff - PTR_W'(1);
               d_ra        = d_top_a - ADDR_W'(2) - idx_a;
               if (sts.shallow) begin
                  status_in = dswe_pkg::ST_SHALLOW;
               end
            end
            dswe_pkg::CMD_SVPICK: begin
               data_top_in = data_top_ff - PTR_W'(1);
               s_ra        = s_top_a - ADDR_W'(1) - idx_a;
               if (sts.shallow) begin
                  status_in = dswe_pkg::ST_SHALLOW;
               end
            end
            default: begin
               d_ra = '0;
            end
         endcase
      end

      if (ctl.cap_b) begin
         b_in = (cmd_ff == dswe_pkg::CMD_SVPICK) ? s_rdata : d_rdata;
      end

      if (ctl.wr1) begin
         case (cmd_ff)
            dswe_pkg::CMD_PUSH: begin
               dpush = 1'b1;
               pw    = word_ff;
            end
            dswe_pkg::CMD_DEPTH: begin
               dpush = 1'b1;
               pw    = WORD_W'(data_top_ff);
            end
            dswe_pkg::CMD_SVDEPTH: begin
               dpush = 1'b1;
               pw    = WORD_W'(save_top_ff);
            end
            dswe_pkg::CMD_PICK, dswe_pkg::CMD_SVPICK: begin
               dpush = 1'b1;
               pw    = b_ff;
            end
            dswe_pkg::CMD_SVPUSH: begin
               spush = 1'b1;
               pw    = a_ff;
            end
            dswe_pkg::CMD_SWAP: begin
               d_we = 1'b1;
               d_wa = d_top_a - ADDR_W'(1);
               d_wd = b_ff;
            end
            default: begin
               dpush = 1'b1;
               pw    = a_ff;
            end
         endcase
      end

      if (ctl.wr2) begin
         if (cmd_ff == dswe_pkg::CMD_SWAP) begin
            d_we = 1'b1;
            d_wa = d_top_a - ADDR_W'(2);
            d_wd = a_ff;
         end else begin
            dpush = 1'b1;
            pw    = b_ff;
         end
      end

      // push with pointer wrap on a full stack
      if (dpush) begin
         d_we        = 1'b1;
         d_wa        = d_full ? '0 : d_top_a;
         d_wd        = pw;
         data_top_in = d_full ? PTR_W'(1) : data_top_ff + PTR_W'(1);
         if (d_full && (status_ff == dswe_pkg::ST_OK)) begin
            status_in = dswe_pkg::ST_OVER;
         end
      end
      if (spush) begin
         s_we        = 1'b1;
         s_wa        = s_full ? '0 : s_top_a;
         s_wd        = pw;
         save_top_in = s_full ? PTR_W'(1) : save_top_ff + PTR_W'(1);
         if (s_full && (status_ff == dswe_pkg::ST_OK)) begin
            status_in = dswe_pkg::ST_OVER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_top_ff <= '0;
         save_top_ff <= '0;
      end else begin
         data_top_ff <= data_top_in;
         save_top_ff <= save_top_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      word_ff   <= word_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
   end

   dswe_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_wa),
      .wr_data (d_wd),
      .rd_addr (d_ra),
      .rd_data (d_rdata)
   );

   dswe_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_save_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_wa),
      .wr_data (s_wd),
      .rd_addr (s_ra),
      .rd_data (s_rdata)
   );

   assign rsp_top_word   = popped_ff;
   assign rsp_status     = status_ff;
   assign rsp_data_count = dswe_pkg::CNT_W'(data_top_ff);
   assign rsp_save_count = dswe_pkg::CNT_W'(save_top_ff);

   `DSWE_ASSERT_NEXT(a_load_clears, ctl.load, (status_ff == dswe_pkg::ST_OK) && (popped_ff == '0))
   `DSWE_ASSERT_NEXT(a_push_wrap, ctl.wr1 && (cmd_ff == dswe_pkg::CMD_PUSH) && d_full,
      (data_top_ff == PTR_W'(1)) && (status_ff == dswe_pkg::ST_OVER))
   `DSWE_ASSERT_SAME(a_data_top_range, 1'b1, data_top_ff <= PTR_W'(STACK_DEPTH))

endmodule
